FILE: rtl/mode_select_list_checker_top_defines.svh
// assertion macros for the mode select list checker
`ifndef MODE_SELECT_LIST_CHECKER_TOP_DEFINES_SVH
`define MODE_SELECT_LIST_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is low
`define MSLC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MSLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MSLC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define MSLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: rtl/mslc_pkg.sv
// constants and codes for the mode select list checker
package mslc_pkg;

    // input item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // verdict codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_FIELD  = 2'd2;

    // header lengths of the two command variants
    localparam logic [15:0] HEADER_TEN = 16'd8;
    localparam logic [15:0] HEADER_SIX = 16'd4;

    // header byte positions that carry the block descriptor length
    localparam logic [2:0] TEN_DESC_HI_IDX = 3'd6;
    localparam logic [2:0] TEN_DESC_LO_IDX = 3'd7;
    localparam logic [2:0] SIX_DESC_IDX    = 3'd3;

    // mode page constants
    localparam logic [7:0] FORMAT_PAGE       = 8'h03;
    localparam logic [8:0] FORMAT_MIN_SIZE   = 9'd14;
    localparam logic [8:0] SECTOR_HI_OFFSET  = 9'd12;
    localparam logic [8:0] SECTOR_LO_OFFSET  = 9'd13;
    localparam logic [8:0] PAGE_HEADER_BYTES = 9'd2;

    // sector size after reset
    localparam logic [15:0] LBA_SIZE_RESET = 16'd512;

endpackage

FILE: rtl/mode_select_list_checker_top.sv
// Mode select parameter list checker: one start transaction opens a check, then the list
// bytes follow one per transaction, and the verdict comes out on the final byte (or at once
// on the start transaction when PF is clear or the lengths are bad). Every input transaction
// is registered as it is taken, and its result, if any, is in the output register the next cycle;
// the only thing that holds the input back is a verdict still waiting in that register, so
// the rate is one item per cycle whenever the result side takes what it is offered.
// The sector size register may be written only while no check is in progress.
`include "mode_select_list_checker_top_defines.svh"

module mode_select_list_checker_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // lba size in bytes
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // is_ten_byte, page_format, list_length[15:0],
                                       // available_length[15:0], data_byte[7:0], zero pad
    input  logic        s_tuser,       // kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // status[1:0], unknown_seen, unknown_page_code[7:0],
                                       // zero pad
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_DESCR,
        PH_PAGES
    } phase_t;

    // registers
    phase_t      phase_reg, phase_next;
    logic [15:0] lba_size_reg;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic        ten_byte_reg, ten_byte_next;
    logic [15:0] desc_left_reg, desc_left_next;
    logic [8:0]  page_index_reg, page_index_next;
    logic [8:0]  page_size_reg, page_size_next;
    logic [7:0]  page_code_reg, page_code_next;
    logic [7:0]  size_high_reg, size_high_next;
    logic [1:0]  error_reg, error_next;
    logic        valid_page_reg, valid_page_next;
    logic        unk_seen_reg, unk_seen_next;
    logic [7:0]  unk_code_reg, unk_code_next;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic        out_seen_reg;
    logic [7:0]  out_code_reg;

    // result of the current transaction
    logic        res_valid;
    logic [1:0]  res_status;
    logic        res_seen;
    logic [7:0]  res_code;

    // input fields
    logic        in_fire;
    logic        in_kind;
    logic        in_ten;
    logic        in_pf;
    logic [15:0] in_len;
    logic [15:0] in_avail;
    logic [7:0]  in_byte;

    assign in_kind  = s_tuser;
    assign in_ten   = s_tdata[0];
    assign in_pf    = s_tdata[1];
    assign in_len   = s_tdata[17:2];
    assign in_avail = s_tdata[33:18];
    assign in_byte  = s_tdata[41:34];

    // take a transaction whenever the result register is free or being emptied
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_code_reg, out_seen_reg, out_status_reg};

    // per-transaction check logic
    always_comb begin
        logic [15:0] hlen;
        logic [15:0] left_dec;
        logic [15:0] desc_val;
        logic        hdr_last;
        logic [8:0]  size;
        logic [8:0]  idx_inc;
        logic        page_ok;
        logic [1:0]  final_status;

        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        header_index_next = header_index_reg;
        ten_byte_next     = ten_byte_reg;
        desc_left_next    = desc_left_reg;
        page_index_next   = page_index_reg;
        page_size_next    = page_size_reg;
        page_code_next    = page_code_reg;
        size_high_next    = size_high_reg;
        error_next        = error_reg;
        valid_page_next   = valid_page_reg;
        unk_seen_next     = unk_seen_reg;
        unk_code_next     = unk_code_reg;

        res_valid  = 1'b0;
        res_status = mslc_pkg::STATUS_OK;
        res_seen   = 1'b0;
        res_code   = 8'd0;

        hlen         = in_ten ? mslc_pkg::HEADER_TEN : mslc_pkg::HEADER_SIX;
        left_dec     = bytes_left_reg - 16'd1;
        desc_val     = desc_left_reg;
        hdr_last     = 1'b0;
        size         = {1'b0, in_byte} + mslc_pkg::PAGE_HEADER_BYTES;
        idx_inc      = page_index_reg + 9'd1;
        page_ok      = 1'b1;
        final_status = mslc_pkg::STATUS_OK;

        if (in_fire) begin
            if (in_kind == mslc_pkg::KIND_START) begin
                // start: clear the check and test the lengths
                phase_next        = PH_IDLE;
                bytes_left_next   = 16'd0;
                header_index_next = 3'd0;
                ten_byte_next     = in_ten;
                desc_left_next    = 16'd0;
                page_index_next   = 9'd0;
                page_size_next    = 9'd0;
                page_code_next    = 8'd0;
                size_high_next    = 8'd0;
                error_next        = mslc_pkg::STATUS_OK;
                valid_page_next   = 1'b0;
                unk_seen_next     = 1'b0;
                unk_code_next     = 8'd0;
                if (!in_pf) begin
                    res_valid  = 1'b1;
                    res_status = mslc_pkg::STATUS_OK;
                end else if (in_len < hlen || in_len > in_avail) begin
                    res_valid  = 1'b1;
                    res_status = mslc_pkg::STATUS_LENGTH;
                end else begin
                    bytes_left_next = in_len;
                    phase_next      = PH_HEADER;
                end
            end else if (phase_reg != PH_IDLE) begin
                bytes_left_next = left_dec;
                if (error_reg == mslc_pkg::STATUS_OK) begin
                    case (phase_reg)
                        PH_HEADER: begin
                            // header byte: pick up the descriptor length
                            if (ten_byte_reg) begin
                                if (header_index_reg == mslc_pkg::TEN_DESC_HI_IDX) begin
                                    size_high_next = in_byte;
                                end
                                if (header_index_reg == mslc_pkg::TEN_DESC_LO_IDX) begin
                                    desc_val = {size_high_reg, in_byte};
                                end
                                hdr_last = (header_index_reg == mslc_pkg::TEN_DESC_LO_IDX);
                            end else begin
                                if (header_index_reg == mslc_pkg::SIX_DESC_IDX) begin
                                    desc_val = {8'd0, in_byte};
                                end
                                hdr_last = (header_index_reg == mslc_pkg::SIX_DESC_IDX);
                            end
                            desc_left_next    = desc_val;
                            header_index_next = header_index_reg + 3'd1;
                            if (hdr_last) begin
                                if (desc_val > left_dec) begin
                                    error_next = mslc_pkg::STATUS_LENGTH;
                                end else begin
                                    page_index_next = 9'd0;
                                    phase_next = (desc_val != 16'd0) ? PH_DESCR : PH_PAGES;
                                end
                            end
                        end
                        PH_DESCR: begin
                            // skip block descriptors
                            desc_left_next = desc_left_reg - 16'd1;
                            if (desc_left_reg == 16'd1) begin
                                page_index_next = 9'd0;
                                phase_next      = PH_PAGES;
                            end
                        end
                        PH_PAGES: begin
                            // mode page walk
                            if (page_index_reg == 9'd0) begin
                                if (bytes_left_reg < 16'd2) begin
                                    error_next = mslc_pkg::STATUS_LENGTH;
                                    page_ok    = 1'b0;
                                end else begin
                                    page_code_next = in_byte;
                                end
                            end else if (page_index_reg == 9'd1) begin
                                if ({8'd0, size} > {1'b0, bytes_left_reg} + 17'd1) begin
                                    error_next = mslc_pkg::STATUS_LENGTH;
                                    page_ok    = 1'b0;
                                end else if (page_code_reg == mslc_pkg::FORMAT_PAGE &&
                                             size < mslc_pkg::FORMAT_MIN_SIZE) begin
                                    error_next = mslc_pkg::STATUS_FIELD;
                                    page_ok    = 1'b0;
                                end else begin
                                    if (page_code_reg != mslc_pkg::FORMAT_PAGE) begin
                                        unk_seen_next = 1'b1;
                                        unk_code_next = page_code_reg;
                                    end
                                    page_size_next = size;
                                end
                            end else if (page_code_reg == mslc_pkg::FORMAT_PAGE &&
                                         page_index_reg == mslc_pkg::SECTOR_HI_OFFSET) begin
                                size_high_next = in_byte;
                            end else if (page_code_reg == mslc_pkg::FORMAT_PAGE &&
                                         page_index_reg == mslc_pkg::SECTOR_LO_OFFSET) begin
                                if ({size_high_reg, in_byte} != lba_size_reg) begin
                                    error_next = mslc_pkg::STATUS_FIELD;
                                    page_ok    = 1'b0;
                                end else begin
                                    valid_page_next = 1'b1;
                                end
                            end
                            if (page_ok) begin
                                if (idx_inc >= 9'd2 && idx_inc == page_size_next) begin
                                    page_index_next = 9'd0;
                                end else begin
                                    page_index_next = idx_inc;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // final byte: give the verdict
                if (left_dec == 16'd0) begin
                    phase_next   = PH_IDLE;
                    final_status = error_next;
                    if (final_status == mslc_pkg::STATUS_OK && !valid_page_next) begin
                        final_status = mslc_pkg::STATUS_FIELD;
                    end
                    res_valid  = 1'b1;
                    res_status = final_status;
                    if (final_status == mslc_pkg::STATUS_OK) begin
                        res_seen = unk_seen_next;
                        res_code = unk_code_next;
                    end
                end
            end
        end
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            lba_size_reg     <= mslc_pkg::LBA_SIZE_RESET;
            bytes_left_reg   <= 16'd0;
            header_index_reg <= 3'd0;
            ten_byte_reg     <= 1'b0;
            desc_left_reg    <= 16'd0;
            page_index_reg   <= 9'd0;
            page_size_reg    <= 9'd0;
            page_code_reg    <= 8'd0;
            size_high_reg    <= 8'd0;
            error_reg        <= mslc_pkg::STATUS_OK;
            valid_page_reg   <= 1'b0;
            unk_seen_reg     <= 1'b0;
            unk_code_reg     <= 8'd0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                lba_size_reg <= cfg_wdata;
            end
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            header_index_reg <= header_index_next;
            ten_byte_reg     <= ten_byte_next;
            desc_left_reg    <= desc_left_next;
            page_index_reg   <= page_index_next;
            page_size_reg    <= page_size_next;
            page_code_reg    <= page_code_next;
            size_high_reg    <= size_high_next;
            error_reg        <= error_next;
            valid_page_reg   <= valid_page_next;
            unk_seen_reg     <= unk_seen_next;
            unk_code_reg     <= unk_code_next;
            if (in_fire) begin
                out_valid_reg <= res_valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        // result payload
        if (in_fire && res_valid) begin
            out_status_reg <= res_status;
            out_seen_reg   <= res_seen;
            out_code_reg   <= res_code;
        end
    end

    // checks
    `MSLC_ASSERT_IMPL(a_idle_no_bytes, aclk, aresetn, phase_reg == PH_IDLE,
        bytes_left_reg == 16'd0, "idle with bytes left")
    `MSLC_ASSERT_IMPL(a_busy_has_bytes, aclk, aresetn, phase_reg != PH_IDLE,
        bytes_left_reg != 16'd0, "check in progress with no bytes left")
    `MSLC_ASSERT_IMPL(a_error_clean, aclk, aresetn,
        m_tvalid && m_tdata[1:0] != mslc_pkg::STATUS_OK,
        m_tdata[2] == 1'b0 && m_tdata[10:3] == 8'd0, "error verdict carries page code")
    `MSLC_ASSERT_IMPL(a_error_code, aclk, aresetn, 1'b1,
        error_reg != 2'd3, "latched error out of range")
    `MSLC_ASSERT_NEXT(a_pf_clear, aclk, aresetn, in_fire && !s_tuser && !s_tdata[1],
        m_tvalid && m_tdata[1:0] == mslc_pkg::STATUS_OK, "pf clear without ok verdict")

endmodule
